>>> hdl/dla_pkg.sv
// Shared types and constants for the debounced limit alarm.
// Used by the interfaces, the front, queue, back and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dla_pkg;

    localparam int NUM_DEVICES  = 16;
    localparam int NUM_CHANNELS = 64;
    localparam int NUM_ENTRIES  = NUM_DEVICES * NUM_CHANNELS;
    localparam int ADDR_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    localparam int DEV_W   = 4;
    localparam int CH_W    = 6;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 8;
    localparam int CLASS_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(3);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CLASS_W-1:0] {
        CLS_NORMAL = 2'd0,
        CLS_LOW    = 2'd1,
        CLS_HIGH   = 2'd2
    } class_t;

    // One entry of the per-channel track store
    typedef struct packed {
        class_t             committed;
        class_t             pending;
        logic [CNT_W-1:0]   count;
    } track_t;

    localparam int TRACK_W = $bits(track_t);

    // Classified transaction handed from front to back
    typedef struct packed {
        logic [DEV_W-1:0]   device;
        logic [CH_W-1:0]    channel;
        class_t             cand;
        logic               in_range;
        logic [ADDR_W-1:0]  addr;
    } item_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

>>> hdl/dla_in_if.sv
// Sample channel: valid/ready handshake plus sample payload.
// Depends on dla_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dla_in_if;
    logic                               valid;
    logic                               ready;
    logic [dla_pkg::DEV_W-1:0]          device;
    logic [dla_pkg::CH_W-1:0]           channel;
    logic signed [dla_pkg::DATA_W-1:0]  sample;
    logic signed [dla_pkg::DATA_W-1:0]  upper_limit;
    logic signed [dla_pkg::DATA_W-1:0]  lower_limit;

    modport source (output valid, device, channel, sample, upper_limit, lower_limit,
                    input ready);
    modport sink   (input valid, device, channel, sample, upper_limit, lower_limit,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/dla_out_if.sv
// Result channel: valid/ready handshake plus alarm payload.
// Depends on dla_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dla_out_if;
    logic                           valid;
    logic                           ready;
    logic                           alarm_raised;
    logic [dla_pkg::CLASS_W-1:0]    severity;
    logic [dla_pkg::CLASS_W-1:0]    committed_class;
    logic [dla_pkg::DEV_W-1:0]      device_out;
    logic [dla_pkg::CH_W-1:0]       channel_out;

    modport source (output valid, alarm_raised, severity, committed_class, device_out,
                    channel_out, input ready);
    modport sink   (input valid, alarm_raised, severity, committed_class, device_out,
                    channel_out, output ready);
endinterface

`default_nettype wire

>>> hdl/dla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/dla_front.sv
// Front end: accepts samples, classifies them against the limits and forms
// the store address. Depends on dla_pkg and dla_in_if.
`timescale 1ns / 1ps
`default_nettype none

module dla_front (
    dla_in_if.sink                  in_ch,
    input  wire logic               clearing,
    input  wire logic               q_full,
    output logic                    push,
    output dla_pkg::item_t          push_item
);

    dla_pkg::class_t cand;

    assign in_ch.ready = !clearing && !q_full;
    assign push        = in_ch.valid && in_ch.ready;

    // high wins over low when the limits are inverted
    always_comb
    begin
        if (in_ch.sample > in_ch.upper_limit)
        begin
            cand = dla_pkg::CLS_HIGH;
        end
        else if (in_ch.sample < in_ch.lower_limit)
        begin
            cand = dla_pkg::CLS_LOW;
        end
        else
        begin
            cand = dla_pkg::CLS_NORMAL;
        end
    end

    always_comb
    begin
        push_item.device   = in_ch.device;
        push_item.channel  = in_ch.channel;
        push_item.cand     = cand;
        push_item.in_range = (32'(in_ch.device) < dla_pkg::NUM_DEVICES) &&
                             (32'(in_ch.channel) < dla_pkg::NUM_CHANNELS);
        push_item.addr     = dla_pkg::ADDR_W'(dla_pkg::ADDR_W'(in_ch.device) *
                                              dla_pkg::ADDR_W'(dla_pkg::NUM_CHANNELS))
                             + dla_pkg::ADDR_W'(in_ch.channel);
    end

endmodule

`default_nettype wire

>>> hdl/dla_queue.sv
// Short FIFO of classified transactions between front and back.
// Depends on dla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dla_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dla_pkg::item_t     push_item,
    input  wire logic               pop,
    output dla_pkg::item_t          pop_item,
    output logic                    not_empty,
    output logic                    full
);

    dla_pkg::item_t                 slot_reg [dla_pkg::QUEUE_DEPTH];
    logic [dla_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dla_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dla_pkg::QPTR_W:0]       fill_reg, fill_next;

    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg == (dla_pkg::QPTR_W + 1)'(dla_pkg::QUEUE_DEPTH));
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? dla_pkg::QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? dla_pkg::QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dla_back.sv
// Back end: clears the track store after reset, then does one read-modify-write
// per in-range transaction with forwarding, and holds the result register.
// Depends on dla_pkg, dla_out_if and dla_ram.
`timescale 1ns / 1ps
`default_nettype none

module dla_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [dla_pkg::CNT_W-1:0]  cfg_wr_data,
    input  wire logic                       q_not_empty,
    input  wire dla_pkg::item_t             q_item,
    output logic                            pop,
    output logic                            clearing,
    dla_out_if.source                       out_ch
);

    dla_pkg::back_state_t           state_reg, state_next;
    logic [dla_pkg::ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [dla_pkg::CNT_W-1:0]      debounce_reg;

    logic                           s2_valid_reg, s2_valid_next;
    dla_pkg::item_t                 s2_item_reg;
    logic                           fwd_hit_reg;
    dla_pkg::track_t                fwd_data_reg;

    logic                           out_valid_reg, out_valid_next;
    logic                           alarm_reg;
    dla_pkg::class_t                sev_reg;
    dla_pkg::class_t                commit_reg;
    logic [dla_pkg::DEV_W-1:0]      dev_reg;
    logic [dla_pkg::CH_W-1:0]       ch_reg;

    logic [dla_pkg::TRACK_W-1:0]    ram_rd_data;
    logic                           ram_wr_en;
    logic [dla_pkg::ADDR_W-1:0]     ram_wr_addr;
    dla_pkg::track_t                ram_wr_data;

    dla_pkg::track_t                cur;
    dla_pkg::track_t                upd;
    logic                           raised;
    logic [dla_pkg::CNT_W-1:0]      run_base;
    logic [dla_pkg::CNT_W-1:0]      run_inc;
    logic                           out_free;
    logic                           s2_fire;
    logic                           upd_write;
    logic                           clr_last;

    // ---------------- clear sequencer ----------------
    assign clr_last = (clr_addr_reg == dla_pkg::ADDR_W'(dla_pkg::NUM_ENTRIES - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dla_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = dla_pkg::ST_RUN;
                end
            end
            dla_pkg::ST_RUN:
            begin
                state_next = dla_pkg::ST_RUN;
            end
            default:
            begin
                state_next = dla_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clearing      = 1'b0;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            dla_pkg::ST_CLEAR:
            begin
                clearing      = 1'b1;
                clr_addr_next = dla_pkg::ADDR_W'(clr_addr_reg + 1'b1);
            end
            dla_pkg::ST_RUN:
            begin
                clearing = 1'b0;
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    // ---------------- update stage ----------------
    assign cur      = fwd_hit_reg ? fwd_data_reg : dla_pkg::track_t'(ram_rd_data);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign s2_fire  = s2_valid_reg && out_free;
    assign pop      = !clearing && q_not_empty && (!s2_valid_reg || s2_fire);
    assign upd_write = s2_fire && s2_item_reg.in_range;

    always_comb
    begin
        upd      = cur;
        raised   = 1'b0;
        run_base = (s2_item_reg.cand != cur.pending) ? '0 : cur.count;
        run_inc  = (run_base == dla_pkg::CNT_MAX) ? run_base : run_base + 1'b1;
        if (s2_item_reg.cand == cur.committed)
        begin
            upd.pending = s2_item_reg.cand;
            upd.count   = '0;
        end
        else
        begin
            upd.pending = s2_item_reg.cand;
            upd.count   = run_inc;
            if (run_inc >= debounce_reg)
            begin
                upd.committed = s2_item_reg.cand;
                upd.count     = '0;
                raised        = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (clearing)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '{committed: dla_pkg::CLS_NORMAL, pending: dla_pkg::CLS_NORMAL,
                            count: '0};
        end
        else
        begin
            ram_wr_en   = upd_write;
            ram_wr_addr = s2_item_reg.addr;
            ram_wr_data = upd;
        end
    end

    dla_ram #(
        .WIDTH (dla_pkg::TRACK_W),
        .DEPTH (dla_pkg::NUM_ENTRIES)
    ) u_track_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (pop),
        .rd_addr (q_item.addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (pop)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_fire)
        begin
            s2_valid_next = 1'b0;
        end
        out_valid_next = s2_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dla_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            debounce_reg  <= dla_pkg::DEBOUNCE_RESET;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                debounce_reg <= cfg_wr_data;
            end
        end
    end

    // the RAM read issued on pop misses a write to the same entry at that edge
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_item_reg  <= q_item;
            fwd_hit_reg  <= upd_write && (q_item.addr == s2_item_reg.addr);
            fwd_data_reg <= upd;
        end
        if (s2_fire)
        begin
            alarm_reg  <= s2_item_reg.in_range && raised;
            sev_reg    <= (s2_item_reg.in_range && raised) ? s2_item_reg.cand
                                                           : dla_pkg::CLS_NORMAL;
            commit_reg <= s2_item_reg.in_range ? upd.committed : dla_pkg::CLS_NORMAL;
            dev_reg    <= s2_item_reg.device;
            ch_reg     <= s2_item_reg.channel;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.alarm_raised    = alarm_reg;
    assign out_ch.severity        = sev_reg;
    assign out_ch.committed_class = commit_reg;
    assign out_ch.device_out      = dev_reg;
    assign out_ch.channel_out     = ch_reg;

endmodule

`default_nettype wire

>>> hdl/debounced_limit_alarm.sv
// Top level of the debounced limit alarm: front, transaction queue and back.
// Depends on dla_pkg, dla_in_if, dla_out_if, dla_front, dla_queue, dla_back.
//
//  port       dir   kind        contents
//  in_ch      in    valid/ready device, channel, sample, upper_limit, lower_limit
//  out_ch     out   valid/ready alarm_raised, severity, committed_class, device_out, channel_out
//  cfg_wr_*   in    write only  debounce_count
//
// One transaction per cycle sustained while out_ch.ready stays high; the result passes
// through three registers after the accepting edge: queue slot, track RAM read, result register.
// One read-modify-write of the track RAM per cycle, with forwarding of the
// write made at the same edge, sets that rate.
// After reset a clearing pass writes every track entry, NUM_ENTRIES (1024) of them,
// with in_ch.ready low; configuration writes are taken throughout.
// A stalled result holds in its register while up to four transactions queue.
`timescale 1ns / 1ps
`default_nettype none

module debounced_limit_alarm (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    dla_in_if.sink                          in_ch,
    dla_out_if.source                       out_ch,
    input  wire logic                       cfg_wr_en,
    input  wire logic [dla_pkg::CNT_W-1:0]  cfg_wr_data
);

    logic               clearing;
    logic               q_full;
    logic               q_not_empty;
    logic               push;
    logic               pop;
    dla_pkg::item_t     push_item;
    dla_pkg::item_t     q_item;

    dla_front u_front (
        .in_ch     (in_ch),
        .clearing  (clearing),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    dla_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (q_item),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    dla_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .pop         (pop),
        .clearing    (clearing),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

>>> hdl/dla_checker.sv
// Port-level checks for the debounced limit alarm, bound to the top level.
// Depends on dla_pkg and debounced_limit_alarm.
`timescale 1ns / 1ps
`default_nettype none

module dla_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_ready,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic                           alarm_raised,
    input  wire logic [dla_pkg::CLASS_W-1:0]    severity,
    input  wire logic [dla_pkg::CLASS_W-1:0]    committed_class,
    input  wire logic [dla_pkg::DEV_W-1:0]      device_out,
    input  wire logic [dla_pkg::CH_W-1:0]       channel_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(alarm_raised) &&
        $stable(severity) && $stable(committed_class) && $stable(device_out) &&
        $stable(channel_out))
        else $error("result changed while stalled");

    // store clearing blocks input right after reset
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input ready during store clear");

    a_quiet_sev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !alarm_raised |-> severity == dla_pkg::CLASS_W'(dla_pkg::CLS_NORMAL))
        else $error("severity set without alarm");

    // a commit reports the class it commits
    a_alarm_sev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alarm_raised |-> severity == committed_class)
        else $error("alarm severity differs from committed class");

endmodule

bind debounced_limit_alarm dla_checker u_dla_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .alarm_raised    (out_ch.alarm_raised),
    .severity        (out_ch.severity),
    .committed_class (out_ch.committed_class),
    .device_out      (out_ch.device_out),
    .channel_out     (out_ch.channel_out)
);

`default_nettype wire
